FILE: rtl/core/subarray_target_sum_window_assert.svh
`ifndef SUBARRAY_TARGET_SUM_WINDOW_ASSERT_SVH
`define SUBARRAY_TARGET_SUM_WINDOW_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define STW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define STW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/stw_pkg.sv
package stw_pkg;

  localparam int unsigned TARGET_W      = 42;
  localparam int unsigned ELEM_IN_W     = 32;
  localparam int unsigned POS_W         = 11;
  localparam int unsigned MAX_LEN_DEF   = 1024;
  localparam int unsigned ELEM_BITS_DEF = 32;

endpackage

FILE: rtl/core/subarray_target_sum_window.sv
// Finds the first contiguous run of non-negative elements whose sum equals target_sum,
// using a two-pointer window over an on-chip element store of MAX_LEN entries. Elements
// arrive one per transaction; the transaction with is_last_i set closes the sequence
// and produces one result (found, 1-based first/last positions, overflow), after which
// all sequence state clears. No new element is taken until the last is fully handled;
// each element dropped from the window head needs one store read and one subtract,
// and the last element loads the result register, serialized by the single store read
// port and shared add/subtract unit. Elements beyond MAX_LEN are dropped and flagged.
// target_sum may be rewritten between sequences through cfg_we_i/cfg_wdata_i.
`include "subarray_target_sum_window_assert.svh"

module subarray_target_sum_window #(
  parameter int unsigned MAX_LEN   = stw_pkg::MAX_LEN_DEF,
  parameter int unsigned ELEM_BITS = stw_pkg::ELEM_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stw_pkg::TARGET_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [stw_pkg::ELEM_IN_W-1:0] element_value_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [stw_pkg::POS_W-1:0]     first_position_o,
  output logic [stw_pkg::POS_W-1:0]     last_position_o,
  output logic                          overflowed_o
);

  localparam int unsigned AW    = $clog2(MAX_LEN);
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned SUM_W =
    ((ELEM_BITS > stw_pkg::TARGET_W) ? ELEM_BITS : stw_pkg::TARGET_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;

  logic [stw_pkg::TARGET_W-1:0] target_q;
  logic [2:0]                   state_q, state_d;
  logic [SUM_W-1:0]             sum_q, sum_d;
  logic [CNT_W-1:0]             head_q, head_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [CNT_W-1:0]             mstart_q, mstart_d;
  logic [CNT_W-1:0]             mend_q, mend_d;
  logic                         match_q, match_d;
  logic                         ovf_q, ovf_d;
  logic                         last_q, last_d;
  logic                         scan_q, scan_d;
  logic                         out_valid_q, out_valid_d;
  logic                         wr_en, rd_en, load_out;
  logic [ELEM_BITS-1:0]         elem;
  logic [SUM_W-1:0]             tgt;
  logic [ELEM_BITS-1:0]         mem [MAX_LEN];
  logic [ELEM_BITS-1:0]         rd_data_q;
  logic                         found_q, ovf_out_q;
  logic [stw_pkg::POS_W-1:0]    first_q, last_pos_q;

  assign elem        = ELEM_BITS'(element_value_i);
  assign tgt         = SUM_W'(target_q);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o          = found_q;
  assign first_position_o = first_q;
  assign last_position_o  = last_pos_q;
  assign overflowed_o     = ovf_out_q;

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    head_d      = head_q;
    count_d     = count_q;
    mstart_d    = mstart_q;
    mend_d      = mend_q;
    match_d     = match_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    scan_d      = scan_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = is_last_i;
          scan_d = 1'b0;
          if (count_q == CNT_W'(MAX_LEN)) begin
            ovf_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CNT_W'(1);
            if (!match_q) begin
              sum_d  = sum_q + SUM_W'(elem);
              scan_d = 1'b1;
            end
          end
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_q && (sum_q > tgt) && ((head_q + CNT_W'(1)) < count_q)) begin
          rd_en   = 1'b1;
          state_d = S_SUB;
        end else begin
          if (scan_q && (sum_q == tgt)) begin
            match_d  = 1'b1;
            mstart_d = head_q + CNT_W'(1);
            mend_d   = count_q;
          end
          scan_d  = 1'b0;
          state_d = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_SUB: begin
        sum_d   = sum_q - SUM_W'(rd_data_q);
        head_d  = head_q + CNT_W'(1);
        state_d = S_SCAN;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          sum_d    = '0;
          head_d   = '0;
          count_d  = '0;
          mstart_d = '0;
          mend_d   = '0;
          match_d  = 1'b0;
          ovf_d    = 1'b0;
          last_d   = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      state_q     <= S_IDLE;
      sum_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      mstart_q    <= '0;
      mend_q      <= '0;
      match_q     <= 1'b0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      scan_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      state_q     <= state_d;
      sum_q       <= sum_d;
      head_q      <= head_d;
      count_q     <= count_d;
      mstart_q    <= mstart_d;
      mend_q      <= mend_d;
      match_q     <= match_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  // element store: one write port at the tail, one read port at the head
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= elem;
    end
    if (rd_en) begin
      rd_data_q <= mem[head_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      found_q    <= match_q;
      first_q    <= match_q ? stw_pkg::POS_W'(mstart_q) : '0;
      last_pos_q <= match_q ? stw_pkg::POS_W'(mend_q) : '0;
      ovf_out_q  <= ovf_q;
    end
  end

  `STW_ASSERT_NOW(a_head_inside, count_q != '0, head_q < count_q, "window head past stored elements")
  `STW_ASSERT_NEXT(a_sub_advance, state_q == S_SUB, head_q == $past(head_q) + CNT_W'(1), "head did not advance after subtract")
  `STW_ASSERT_NOW(a_ovf_full, ovf_q, count_q == CNT_W'(MAX_LEN), "overflow flagged with store not full")
  `STW_ASSERT_NEXT(a_emit_clears, load_out, (count_q == '0) && !match_q && out_valid_q, "result load did not clear sequence")

endmodule
